### hw/rtl/clcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and the init word table of the character LCD command
// sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam logic [1:0] FUNC_INIT   = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_CURSOR = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [2:0] REG_FOUR_BIT    = 3'd0;
	localparam logic [2:0] REG_ENTRY_SHIFT = 3'd1;
	localparam logic [2:0] REG_PULSE       = 3'd2;
	localparam logic [2:0] REG_POWER_UP    = 3'd3;
	localparam logic [2:0] REG_CLEAR_EXTRA = 3'd4;

	localparam logic [7:0] INS_FUNC_8BIT   = 8'h38;
	localparam logic [7:0] INS_FUNC_4BIT   = 8'h28;
	localparam logic [7:0] INS_DISPLAY_ON  = 8'h0C;
	localparam logic [7:0] INS_CLEAR       = 8'h01;
	localparam logic [7:0] INS_ENTRY       = 8'h06;
	localparam logic [7:0] INS_ENTRY_SHIFT = 8'h07;
	localparam logic [7:0] INS_HOME_4BIT   = 8'h02;
	localparam logic [7:0] INS_DDRAM       = 8'h80;
	localparam logic [7:0] LINE1_OFFSET    = 8'h40;

	localparam logic [7:0] LINE_0 = 8'd0;
	localparam logic [7:0] LINE_1 = 8'd1;

	localparam logic [2:0] IDX_WAIT    = 3'd0;
	localparam logic [2:0] IDX_HOME4   = 3'd1;
	localparam logic [2:0] IDX_FUNC    = 3'd2;
	localparam logic [2:0] IDX_DISPLAY = 3'd3;
	localparam logic [2:0] IDX_CLEAR   = 3'd4;
	localparam logic [2:0] IDX_ENTRY   = 3'd5;

	typedef struct packed {
		logic       four_bit_bus;
		logic       entry_shift;
		logic [7:0] pulse_ms;
		logic [7:0] power_up_ms;
		logic [7:0] clear_extra_ms;
	} cfg_t;

	typedef struct packed {
		logic       is_wait;
		logic       rs;
		logic [7:0] value;
		logic       clr;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic entry_t init_entry(input logic [2:0] idx, input cfg_t cfg);
		entry_t e;
		e.is_wait = 1'b0;
		e.rs      = 1'b0;
		e.value   = 8'h00;
		e.clr     = 1'b0;
		e.last    = 1'b0;
		unique case (idx)
			IDX_WAIT:    e.is_wait = 1'b1;
			IDX_HOME4:   e.value = INS_HOME_4BIT;
			IDX_FUNC:    e.value = cfg.four_bit_bus ? INS_FUNC_4BIT : INS_FUNC_8BIT;
			IDX_DISPLAY: e.value = INS_DISPLAY_ON;
			IDX_CLEAR: begin
				e.value = INS_CLEAR;
				e.clr   = 1'b1;
			end
			IDX_ENTRY: begin
				e.value = cfg.entry_shift ? INS_ENTRY_SHIFT : INS_ENTRY;
				e.last  = 1'b1;
			end
			default:     e.is_wait = 1'b1;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/clcd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_front
// Accepts commands and breaks each into queued wait and byte entries.
// ----------------------------------------------------------------------------
module clcd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire clcd_pkg::cfg_t     cfg,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         func,
	input  wire logic [7:0]         char_code,
	input  wire logic [7:0]         line,
	input  wire logic [6:0]         cell_req,
	output logic                    push,
	output clcd_pkg::entry_t        push_entry,
	input  wire clcd_pkg::q_status_t q_status
);

	logic       busy_q;
	logic [2:0] idx_q;
	logic [1:0] func_q;
	logic [7:0] char_q;
	logic [7:0] line_q;
	logic [6:0] cell_q;
	logic       done;

	assign cmd_stall = busy_q;

	always_comb begin
		push_entry.is_wait = 1'b0;
		push_entry.rs      = 1'b0;
		push_entry.value   = 8'h00;
		push_entry.clr     = 1'b0;
		push_entry.last    = 1'b1;
		push = busy_q;
		done = 1'b1;
		unique case (func_q)
			clcd_pkg::FUNC_INIT: begin
				push_entry = clcd_pkg::init_entry(idx_q, cfg);
				done = (idx_q == clcd_pkg::IDX_ENTRY);
			end
			clcd_pkg::FUNC_WRITE: begin
				push_entry.rs    = 1'b1;
				push_entry.value = char_q;
			end
			clcd_pkg::FUNC_CURSOR: begin
				if (line_q == clcd_pkg::LINE_0) begin
					push_entry.value = clcd_pkg::INS_DDRAM | {1'b0, cell_q};
				end else if (line_q == clcd_pkg::LINE_1) begin
					push_entry.value = clcd_pkg::INS_DDRAM + clcd_pkg::LINE1_OFFSET
						+ {1'b0, cell_q};
				end else begin
					push = 1'b0;
				end
			end
			clcd_pkg::FUNC_CLEAR: begin
				push_entry.value = clcd_pkg::INS_CLEAR;
				push_entry.clr   = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= clcd_pkg::IDX_WAIT;
		end else if (!busy_q) begin
			if (cmd_valid) begin
				busy_q <= 1'b1;
				idx_q  <= clcd_pkg::IDX_WAIT;
			end
		end else if (!push) begin
			busy_q <= 1'b0;
		end else if (!q_status.full) begin
			if (done) begin
				busy_q <= 1'b0;
			end else if (idx_q == clcd_pkg::IDX_WAIT && !cfg.four_bit_bus) begin
				idx_q <= clcd_pkg::IDX_FUNC;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && cmd_valid) begin
			func_q <= func;
			char_q <= char_code;
			line_q <= line;
			cell_q <= cell_req;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/clcd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_queue
// Two-entry queue between the command front and the step generator.
// ----------------------------------------------------------------------------
module clcd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire clcd_pkg::entry_t    push_entry,
	input  wire logic                pop,
	output clcd_pkg::entry_t         pop_entry,
	output clcd_pkg::q_status_t      status
);

	clcd_pkg::entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push_ok;
	logic       pop_ok;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign push_ok = push && !status.full;
	assign pop_ok  = pop && !status.empty;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/clcd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_back
// Turns queued entries into timed pin steps behind an output register.
// ----------------------------------------------------------------------------
module clcd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire clcd_pkg::cfg_t      cfg,
	output logic                     pop,
	input  wire clcd_pkg::entry_t    pop_entry,
	input  wire clcd_pkg::q_status_t q_status,
	output logic                     step_valid,
	input  wire logic                step_stall,
	output logic                     reg_select,
	output logic                     enable,
	output logic [7:0]               bus,
	output logic [8:0]               hold_ms,
	output logic                     last
);

	logic             busy_q;
	logic [1:0]       step_q;
	clcd_pkg::entry_t entry_q;
	logic             out_valid_q;
	logic             rs_q;
	logic             en_q;
	logic [7:0]       bus_q;
	logic [8:0]       hold_q;
	logic             last_q;

	logic       can_load;
	logic       final_step;
	logic       en_n;
	logic [7:0] bus_n;
	logic [8:0] hold_n;

	assign pop      = !busy_q;
	assign can_load = busy_q && (!out_valid_q || !step_stall);

	always_comb begin
		en_n       = !step_q[0];
		final_step = cfg.four_bit_bus ? (step_q == 2'd3) : (step_q == 2'd1);
		if (!cfg.four_bit_bus) begin
			bus_n = entry_q.value;
		end else if (step_q[1]) begin
			bus_n = {4'h0, entry_q.value[3:0]};
		end else begin
			bus_n = {4'h0, entry_q.value[7:4]};
		end
		if (final_step && entry_q.clr) begin
			hold_n = {1'b0, cfg.pulse_ms} + {1'b0, cfg.clear_extra_ms};
		end else begin
			hold_n = {1'b0, cfg.pulse_ms};
		end
		if (entry_q.is_wait) begin
			en_n       = 1'b0;
			bus_n      = 8'h00;
			hold_n     = {1'b0, cfg.power_up_ms};
			final_step = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (!q_status.empty) begin
					busy_q <= 1'b1;
					step_q <= 2'd0;
				end
			end else if (can_load) begin
				if (final_step) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 2'd1;
			end
			if (can_load) begin
				out_valid_q <= 1'b1;
			end else if (!step_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && !q_status.empty) begin
			entry_q <= pop_entry;
		end
		if (can_load) begin
			rs_q   <= entry_q.rs;
			en_q   <= en_n;
			bus_q  <= bus_n;
			hold_q <= hold_n;
			last_q <= entry_q.last && final_step;
		end
	end

	assign step_valid = out_valid_q;
	assign reg_select = rs_q;
	assign enable     = en_q;
	assign bus        = bus_q;
	assign hold_ms    = hold_q;
	assign last       = last_q;

endmodule
`default_nettype wire

### hw/rtl/char_lcd_command_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer
// Character LCD command sequencer with an APB-style register port.
// ----------------------------------------------------------------------------
// A command is taken while the front is idle and then split by the front into
// wait and byte entries, one per cycle while the two-entry queue is not full;
// the next command is taken once the front has queued every entry of the
// current one. The back loads an entry into a register and then emits one pin
// step per cycle while the step side does not stall; a 4-bit init has 21
// steps. Registers sit at byte addresses 0, 4, 8, 12 and 16; reads return the
// stored bit 0 of the first two and bits 7:0 of the rest, upper bits zero.
// ----------------------------------------------------------------------------
module char_lcd_command_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  line,
	input  wire logic [6:0]  cell_req,
	output logic             step_valid,
	input  wire logic        step_stall,
	output logic             reg_select,
	output logic             enable,
	output logic [7:0]       bus,
	output logic [8:0]       hold_ms,
	output logic             last
);

	clcd_pkg::cfg_t      cfg_q;
	clcd_pkg::entry_t    push_entry;
	clcd_pkg::entry_t    pop_entry;
	clcd_pkg::q_status_t q_status;
	logic                push;
	logic                pop;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_bus   <= 1'b1;
			cfg_q.entry_shift    <= 1'b0;
			cfg_q.pulse_ms       <= 8'd1;
			cfg_q.power_up_ms    <= 8'd50;
			cfg_q.clear_extra_ms <= 8'd1;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				clcd_pkg::REG_FOUR_BIT:    cfg_q.four_bit_bus   <= pwdata[0];
				clcd_pkg::REG_ENTRY_SHIFT: cfg_q.entry_shift    <= pwdata[0];
				clcd_pkg::REG_PULSE:       cfg_q.pulse_ms       <= pwdata[7:0];
				clcd_pkg::REG_POWER_UP:    cfg_q.power_up_ms    <= pwdata[7:0];
				clcd_pkg::REG_CLEAR_EXTRA: cfg_q.clear_extra_ms <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			clcd_pkg::REG_FOUR_BIT:    prdata = {31'd0, cfg_q.four_bit_bus};
			clcd_pkg::REG_ENTRY_SHIFT: prdata = {31'd0, cfg_q.entry_shift};
			clcd_pkg::REG_PULSE:       prdata = {24'd0, cfg_q.pulse_ms};
			clcd_pkg::REG_POWER_UP:    prdata = {24'd0, cfg_q.power_up_ms};
			clcd_pkg::REG_CLEAR_EXTRA: prdata = {24'd0, cfg_q.clear_extra_ms};
			default:                   prdata = 32'd0;
		endcase
	end

	clcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.func       (func),
		.char_code  (char_code),
		.line       (line),
		.cell_req   (cell_req),
		.push       (push),
		.push_entry (push_entry),
		.q_status   (q_status)
	);

	clcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	clcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_status   (q_status),
		.step_valid (step_valid),
		.step_stall (step_stall),
		.reg_select (reg_select),
		.enable     (enable),
		.bus        (bus),
		.hold_ms    (hold_ms),
		.last       (last)
	);

endmodule
`default_nettype wire
